// File: rtl/core/cfp_pkg.sv
// Shared types and constants of the convex frame point test.
package cfp_pkg;

  // Configuration register indexes and widths
  localparam int CFG_INDEX_W = 3;
  localparam int COUNT_W     = 3;
  localparam logic [CFG_INDEX_W-1:0] CFG_CORNER_COUNT = 3'd0;

  // Frame needs at least a triangle
  localparam int MIN_CORNERS = 3;

  // Result word: outside, status, zero pad to a byte
  localparam int STATUS_W    = 2;
  localparam int OUT_TDATA_W = ((1 + STATUS_W + 7) / 8) * 8;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_FEW   = 2'd1,
    STATUS_BAD_FRAME = 2'd2
  } status_t;

  // Frame checker status seen by the top level
  typedef struct packed {
    logic busy;
    logic frame_bad;
  } sweep_stat_t;

endpackage

// File: rtl/core/cfp_edge_setup.sv
// Per-edge geometry registers: start corner and edge vector for every edge.
module cfp_edge_setup #(
  parameter int MAX_CORNERS = 7,
  parameter int COORD_BITS  = 16
) (
  input  logic                             clk,
  input  logic [cfp_pkg::COUNT_W-1:0]      n_eff,
  input  logic signed [COORD_BITS-1:0]     cx [MAX_CORNERS],
  input  logic signed [COORD_BITS-1:0]     cy [MAX_CORNERS],
  output logic signed [COORD_BITS-1:0]     x0 [MAX_CORNERS],
  output logic signed [COORD_BITS-1:0]     y0 [MAX_CORNERS],
  output logic signed [COORD_BITS:0]       dx [MAX_CORNERS],
  output logic signed [COORD_BITS:0]       dy [MAX_CORNERS],
  output logic [MAX_CORNERS-1:0]           degen
);

  for (genvar i = 0; i < MAX_CORNERS; i++) begin : g_edge
    localparam int NXT = (i + 1 < MAX_CORNERS) ? i + 1 : 0;

    logic                         wrap;
    logic signed [COORD_BITS-1:0] bx;
    logic signed [COORD_BITS-1:0] by;
    logic signed [COORD_BITS:0]   ddx;
    logic signed [COORD_BITS:0]   ddy;

    // last corner in use closes back to corner 0
    assign wrap = (cfp_pkg::COUNT_W'(i + 1) >= n_eff);
    assign bx   = wrap ? cx[0] : cx[NXT];
    assign by   = wrap ? cy[0] : cy[NXT];
    assign ddx  = (COORD_BITS+1)'(bx) - (COORD_BITS+1)'(cx[i]);
    assign ddy  = (COORD_BITS+1)'(by) - (COORD_BITS+1)'(cy[i]);

    always_ff @(posedge clk) begin
      x0[i]    <= cx[i];
      y0[i]    <= cy[i];
      dx[i]    <= ddx;
      dy[i]    <= ddy;
      degen[i] <= (ddx == '0) && (ddy == '0);
    end
  end

endmodule

// File: rtl/core/cfp_frame_check.sv
// Frame consistency sweep: one (edge, corner) cross product per cycle after a config write.
module cfp_frame_check #(
  parameter int MAX_CORNERS = 7,
  parameter int COORD_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [cfp_pkg::COUNT_W-1:0]      n_eff,
  input  logic signed [COORD_BITS-1:0]     cx [MAX_CORNERS],
  input  logic signed [COORD_BITS-1:0]     cy [MAX_CORNERS],
  input  logic signed [COORD_BITS-1:0]     x0 [MAX_CORNERS],
  input  logic signed [COORD_BITS-1:0]     y0 [MAX_CORNERS],
  input  logic signed [COORD_BITS:0]       dx [MAX_CORNERS],
  input  logic signed [COORD_BITS:0]       dy [MAX_CORNERS],
  input  logic [MAX_CORNERS-1:0]           degen,
  output cfp_pkg::sweep_stat_t             stat,
  output logic [MAX_CORNERS-1:0]           ref_pos
);

  localparam int IW = $clog2(MAX_CORNERS);
  localparam int QW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = PW + 1;
  localparam int NW = cfp_pkg::COUNT_W;

  typedef enum logic [1:0] {SW_IDLE, SW_WAIT, SW_RUN, SW_DRAIN} state_t;

  state_t                state;
  logic [IW-1:0]         e_idx;
  logic [IW-1:0]         c_idx;
  logic [1:0]            drain_cnt;
  logic                  frame_bad;
  logic [MAX_CORNERS-1:0] pos_seen;
  logic [MAX_CORNERS-1:0] neg_seen;
  logic [MAX_CORNERS-1:0] zero_seen;
  logic [MAX_CORNERS-1:0] edge_used;

  // sweep pipeline
  logic                  v1;
  logic                  v2;
  logic [IW-1:0]         e1;
  logic [IW-1:0]         e2;
  logic signed [QW-1:0]  qx1;
  logic signed [QW-1:0]  qy1;
  logic signed [QW-1:0]  dx1;
  logic signed [QW-1:0]  dy1;
  logic                  dg1;
  logic signed [PW-1:0]  p1;
  logic signed [PW-1:0]  p2;
  logic signed [QW-1:0]  qx2;
  logic                  dg2;

  logic [NW-1:0]         nx_e;
  logic                  pair_ok;
  logic                  last_pair;
  logic signed [SW-1:0]  s3;
  logic                  bad_any;

  assign nx_e = (NW'(e_idx) + NW'(1) < n_eff) ? NW'(e_idx) + NW'(1) : '0;

  // skip the edge's own two corners and corners not in use
  assign pair_ok = (state == SW_RUN) && (NW'(e_idx) < n_eff) && (NW'(c_idx) < n_eff)
                   && (c_idx != e_idx) && (NW'(c_idx) != nx_e);
  assign last_pair = (e_idx == IW'(MAX_CORNERS - 1)) && (c_idx == IW'(MAX_CORNERS - 1));

  // coincident corners: side taken from x alone
  assign s3 = dg2 ? SW'(qx2) : SW'(p1) - SW'(p2);

  for (genvar i = 0; i < MAX_CORNERS; i++) begin : g_used
    assign edge_used[i] = (NW'(i) < n_eff);
  end

  assign bad_any = |((zero_seen | (pos_seen & neg_seen)) & edge_used);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= SW_IDLE;
      e_idx     <= '0;
      c_idx     <= '0;
      drain_cnt <= '0;
      frame_bad <= 1'b0;
      pos_seen  <= '0;
      neg_seen  <= '0;
      zero_seen <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
    end else begin
      v1 <= pair_ok && !start;
      v2 <= v1 && !start;
      if (v2) begin
        if (s3 == '0) begin
          zero_seen[e2] <= 1'b1;
        end else if (s3[SW-1]) begin
          neg_seen[e2] <= 1'b1;
        end else begin
          pos_seen[e2] <= 1'b1;
        end
      end
      case (state)
        SW_IDLE: begin
        end
        SW_WAIT: begin
          // geometry registers settle during this cycle
          pos_seen  <= '0;
          neg_seen  <= '0;
          zero_seen <= '0;
          e_idx     <= '0;
          c_idx     <= '0;
          state     <= SW_RUN;
        end
        SW_RUN: begin
          if (c_idx == IW'(MAX_CORNERS - 1)) begin
            c_idx <= '0;
            // edge index stays on the last edge once the sweep is done
            if (!last_pair) begin
              e_idx <= e_idx + IW'(1);
            end
          end else begin
            c_idx <= c_idx + IW'(1);
          end
          if (last_pair) begin
            drain_cnt <= '0;
            state     <= SW_DRAIN;
          end
        end
        SW_DRAIN: begin
          drain_cnt <= drain_cnt + 2'd1;
          if (drain_cnt == 2'd2) begin
            frame_bad <= bad_any;
            state     <= SW_IDLE;
          end
        end
        default: state <= SW_IDLE;
      endcase
      if (start) begin
        state <= SW_WAIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    e1  <= e_idx;
    qx1 <= QW'(cx[c_idx]) - QW'(x0[e_idx]);
    qy1 <= QW'(cy[c_idx]) - QW'(y0[e_idx]);
    dx1 <= dx[e_idx];
    dy1 <= dy[e_idx];
    dg1 <= degen[e_idx];
    e2  <= e1;
    p1  <= dx1 * qy1;
    p2  <= dy1 * qx1;
    qx2 <= qx1;
    dg2 <= dg1;
  end

  assign stat.busy      = (state != SW_IDLE);
  assign stat.frame_bad = frame_bad;
  assign ref_pos        = pos_seen;

endmodule

// File: rtl/core/cfp_point_pipe.sv
// Point side test: one lane per edge, four stages with per-stage valid and stall.
module cfp_point_pipe #(
  parameter int MAX_CORNERS = 7,
  parameter int COORD_BITS  = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [COORD_BITS-1:0]     px,
  input  logic signed [COORD_BITS-1:0]     py,
  input  logic signed [COORD_BITS-1:0]     x0 [MAX_CORNERS],
  input  logic signed [COORD_BITS-1:0]     y0 [MAX_CORNERS],
  input  logic signed [COORD_BITS:0]       dx [MAX_CORNERS],
  input  logic signed [COORD_BITS:0]       dy [MAX_CORNERS],
  input  logic [MAX_CORNERS-1:0]           degen,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [MAX_CORNERS-1:0]           lane_pos,
  output logic [MAX_CORNERS-1:0]           lane_neg
);

  localparam int QW = COORD_BITS + 1;
  localparam int PW = 2 * COORD_BITS + 2;
  localparam int SW = PW + 1;

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  logic signed [COORD_BITS-1:0] px1;
  logic signed [COORD_BITS-1:0] py1;

  assign en4      = !v4 || out_ready;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) begin
        v1 <= in_valid;
      end
      if (en2) begin
        v2 <= v1;
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      px1 <= px;
      py1 <= py;
    end
  end

  for (genvar i = 0; i < MAX_CORNERS; i++) begin : g_lane
    logic signed [QW-1:0] qx2;
    logic signed [QW-1:0] qy2;
    logic signed [PW-1:0] p1;
    logic signed [PW-1:0] p2;
    logic signed [QW-1:0] qx3;
    logic signed [SW-1:0] s;

    assign s = degen[i] ? SW'(qx3) : SW'(p1) - SW'(p2);

    always_ff @(posedge clk) begin
      if (en2) begin
        qx2 <= QW'(px1) - QW'(x0[i]);
        qy2 <= QW'(py1) - QW'(y0[i]);
      end
      if (en3) begin
        p1  <= dx[i] * qy2;
        p2  <= dy[i] * qx2;
        qx3 <= qx2;
      end
      if (en4) begin
        lane_pos[i] <= (s != '0) && !s[SW-1];
        lane_neg[i] <= s[SW-1];
      end
    end
  end

  assign out_valid = v4;

endmodule

// File: rtl/core/convex_frame_point_test_core.sv
// A request accepted on s_axis passes the point pipeline stages and the result register to m_axis.
// Throughput: one request per cycle unless m_axis stalls or a sweep runs; one edge lane per
// corner, each with two multipliers. A configuration write starts a frame sweep over every
// (edge, corner) pair, one shared cross product per cycle; s_axis_tready is low meanwhile.
// Reset (rst, synchronous, active high) clears the registers to zero corners and empties
// the pipeline; no sweep follows reset.
module convex_frame_point_test_core #(
  parameter int MAX_CORNERS = 7,
  parameter int COORD_BITS  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration write port
  input  logic                                   cfg_we,
  input  logic [cfp_pkg::CFG_INDEX_W-1:0]        cfg_index,
  input  logic [2*COORD_BITS-1:0]                cfg_data,
  // point requests
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]      s_axis_tdata,  // point_x, point_y, pad
  // results
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [cfp_pkg::OUT_TDATA_W-1:0]        m_axis_tdata   // outside, status[1:0], pad
);

  localparam int IW = $clog2(MAX_CORNERS);
  localparam int CW = 2 * COORD_BITS;
  localparam int NW = cfp_pkg::COUNT_W;
  localparam int XW = cfp_pkg::CFG_INDEX_W;

  // ---------------------------------------------------------------------------
  // Configuration registers. Corner k sits at index k+1; corners above
  // MAX_CORNERS are never used, so they are not stored.
  // ---------------------------------------------------------------------------
  logic [NW-1:0]  corner_count;
  logic [CW-1:0]  corner_reg [MAX_CORNERS];
  logic [XW-1:0]  corner_sel;
  logic [NW-1:0]  n_eff;

  assign corner_sel = cfg_index - XW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      corner_count <= '0;
      for (int k = 0; k < MAX_CORNERS; k++) begin
        corner_reg[k] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == cfp_pkg::CFG_CORNER_COUNT) begin
        corner_count <= cfg_data[NW-1:0];
      end else if (corner_sel < XW'(MAX_CORNERS)) begin
        corner_reg[corner_sel[IW-1:0]] <= cfg_data;
      end
    end
  end

  // corner counts above the lane count saturate
  assign n_eff = (corner_count > NW'(MAX_CORNERS)) ? NW'(MAX_CORNERS) : corner_count;

  logic signed [COORD_BITS-1:0] cx [MAX_CORNERS];
  logic signed [COORD_BITS-1:0] cy [MAX_CORNERS];

  for (genvar k = 0; k < MAX_CORNERS; k++) begin : g_corner
    assign cx[k] = $signed(corner_reg[k][CW-1:COORD_BITS]);
    assign cy[k] = $signed(corner_reg[k][COORD_BITS-1:0]);
  end

  // ---------------------------------------------------------------------------
  // Edge geometry, shared by the frame sweep and the point lanes
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] x0 [MAX_CORNERS];
  logic signed [COORD_BITS-1:0] y0 [MAX_CORNERS];
  logic signed [COORD_BITS:0]   dx [MAX_CORNERS];
  logic signed [COORD_BITS:0]   dy [MAX_CORNERS];
  logic [MAX_CORNERS-1:0]       degen;

  cfp_edge_setup #(
    .MAX_CORNERS (MAX_CORNERS),
    .COORD_BITS  (COORD_BITS)
  ) u_edge (
    .clk   (clk),
    .n_eff (n_eff),
    .cx    (cx),
    .cy    (cy),
    .x0    (x0),
    .y0    (y0),
    .dx    (dx),
    .dy    (dy),
    .degen (degen)
  );

  // ---------------------------------------------------------------------------
  // Frame sweep: decides which side each edge keeps its corners on
  // ---------------------------------------------------------------------------
  cfp_pkg::sweep_stat_t     sweep;
  logic [MAX_CORNERS-1:0]   ref_pos;

  cfp_frame_check #(
    .MAX_CORNERS (MAX_CORNERS),
    .COORD_BITS  (COORD_BITS)
  ) u_check (
    .clk     (clk),
    .rst     (rst),
    .start   (cfg_we),
    .n_eff   (n_eff),
    .cx      (cx),
    .cy      (cy),
    .x0      (x0),
    .y0      (y0),
    .dx      (dx),
    .dy      (dy),
    .degen   (degen),
    .stat    (sweep),
    .ref_pos (ref_pos)
  );

  // ---------------------------------------------------------------------------
  // Point pipeline. Requests are held off while a sweep runs and in the
  // cycle of a config write, so every request sees settled geometry.
  // ---------------------------------------------------------------------------
  logic                    pipe_in_ready;
  logic                    pipe_in_valid;
  logic                    pipe_out_valid;
  logic                    out_en;
  logic [MAX_CORNERS-1:0]  lane_pos;
  logic [MAX_CORNERS-1:0]  lane_neg;

  assign s_axis_tready = pipe_in_ready && !sweep.busy && !cfg_we;
  assign pipe_in_valid = s_axis_tvalid && !sweep.busy && !cfg_we;

  cfp_point_pipe #(
    .MAX_CORNERS (MAX_CORNERS),
    .COORD_BITS  (COORD_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (pipe_in_valid),
    .in_ready  (pipe_in_ready),
    .px        ($signed(s_axis_tdata[COORD_BITS-1:0])),
    .py        ($signed(s_axis_tdata[CW-1:COORD_BITS])),
    .x0        (x0),
    .y0        (y0),
    .dx        (dx),
    .dy        (dy),
    .degen     (degen),
    .out_valid (pipe_out_valid),
    .out_ready (out_en),
    .lane_pos  (lane_pos),
    .lane_neg  (lane_neg)
  );

  // ---------------------------------------------------------------------------
  // Result stage: a lane flags outside when its side is nonzero and opposite
  // to the side the other corners keep. Status overrides the flag.
  // ---------------------------------------------------------------------------
  logic [MAX_CORNERS-1:0]          lane_used;
  logic                            any_out;
  cfp_pkg::status_t                status;
  logic                            outside;
  logic [cfp_pkg::OUT_TDATA_W-1:0] out_word;

  for (genvar i = 0; i < MAX_CORNERS; i++) begin : g_used
    assign lane_used[i] = (NW'(i) < n_eff);
  end

  assign any_out = |(lane_used & ((lane_pos & ~ref_pos) | (lane_neg & ref_pos)));

  always_comb begin
    if (n_eff < NW'(cfp_pkg::MIN_CORNERS)) begin
      status = cfp_pkg::STATUS_TOO_FEW;
    end else if (sweep.frame_bad) begin
      status = cfp_pkg::STATUS_BAD_FRAME;
    end else begin
      status = cfp_pkg::STATUS_OK;
    end
    outside = (status == cfp_pkg::STATUS_OK) && any_out;
    out_word = '0;
    out_word[0] = outside;
    out_word[cfp_pkg::STATUS_W:1] = status;
  end

  assign out_en = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_en) begin
      m_axis_tvalid <= pipe_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      m_axis_tdata <= out_word;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_write_starts_sweep : assert property (
    @(posedge clk) disable iff (rst) cfg_we |=> sweep.busy
  ) else $error("config write did not start a frame sweep");

  a_no_request_after_write : assert property (
    @(posedge clk) disable iff (rst) cfg_we |=> !s_axis_tready
  ) else $error("request taken right after a config write");

  a_flag_only_when_ok : assert property (
    @(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[cfp_pkg::STATUS_W:1] != cfp_pkg::STATUS_OK))
      |-> !m_axis_tdata[0]
  ) else $error("outside flag set with a failing status");

endmodule
